/* rtl/auto_brightness_ramp_top_defines.svh */
// assertion macros used by the checker file
`ifndef AUTO_BRIGHTNESS_RAMP_TOP_DEFINES_SVH
`define AUTO_BRIGHTNESS_RAMP_TOP_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define ABR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ABR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/abr_pkg.sv */
// shared types, constants and functions of the brightness ramp
package abr_pkg;

    localparam int NUM_LEVELS  = 11;
    localparam int LVL_W       = 4;
    localparam int PCT_W       = 7;
    localparam int PERIOD_W    = 27;
    localparam int INTERVAL_W  = 8;
    localparam int BASE_W      = 15;
    localparam int STEP_W      = 12;
    localparam int RAW_W       = 16;
    localparam int THR_W       = 17;
    localparam int PROD_W      = PERIOD_W + PCT_W;
    localparam int QUO_W       = PROD_W - 2;
    localparam int CFG_IDX_W   = 2;
    localparam int RECIP_SHIFT = 36;

    typedef logic [LVL_W-1:0]      t_lvl;
    typedef logic [PCT_W-1:0]      t_pct;
    typedef logic [PERIOD_W-1:0]   t_period;
    typedef logic [INTERVAL_W-1:0] t_interval;
    typedef logic [BASE_W-1:0]     t_base;
    typedef logic [STEP_W-1:0]     t_step;
    typedef logic [THR_W-1:0]      t_thr;
    typedef logic [PROD_W-1:0]     t_prod;
    typedef logic [QUO_W-1:0]      t_quo;
    typedef logic [2*QUO_W-1:0]    t_wide;

    // floor(2^36 / 25), quotient estimate low by at most one
    localparam t_quo      RECIP_25       = 32'd2748779069;
    localparam t_quo      DIV_25         = 32'd25;

    localparam t_period   PERIOD_RST     = 27'd1000000;
    localparam t_interval INTERVAL_RST   = 8'd10;
    localparam t_base     BASE_RST       = 15'd30;
    localparam t_step     STEP_RST       = 12'd17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD   = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_BASE     = 2'd2,
        CFG_STEP     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_lvl cur;
        t_lvl goal;
        logic upd;
    } t_lvl_info;

    // duty percentage of a brightness level
    function automatic t_pct pct_of(input t_lvl lvl);
        t_pct pct;
        unique case (lvl)
            4'd0:    pct = 7'd1;
            4'd1:    pct = 7'd5;
            4'd2:    pct = 7'd10;
            4'd3:    pct = 7'd15;
            4'd4:    pct = 7'd20;
            4'd5:    pct = 7'd30;
            4'd6:    pct = 7'd40;
            4'd7:    pct = 7'd50;
            4'd8:    pct = 7'd60;
            4'd9:    pct = 7'd80;
            default: pct = 7'd100;
        endcase
        return pct;
    endfunction

endpackage

/* rtl/abr_in_if.sv */
// input channel: light reading per tick
interface abr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_light;
    logic        sample_ok;

    modport source(output valid, raw_light, sample_ok, input ready);
    modport sink(input valid, raw_light, sample_ok, output ready);
endinterface

/* rtl/abr_out_if.sv */
// output channel: level and duty result per tick
interface abr_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  current_level;
    logic [3:0]  goal_level;
    logic [26:0] duty_ns;
    logic        duty_update;

    modport source(output valid, current_level, goal_level, duty_ns, duty_update, input ready);
    modport sink(input valid, current_level, goal_level, duty_ns, duty_update, output ready);
endinterface

/* rtl/auto_brightness_ramp_top.sv */
// ambient light brightness ramp: goal pick, level step and pwm duty pipeline
//
// One transfer is accepted every cycle while the pipeline advances. Each reading
// passes an input register, the level update stage, a 7x27 multiply for percent
// times period and a two stage divide by 100 (reciprocal multiply plus one
// correction) that ends in the output register. The whole pipeline advances
// whenever the output register is empty or being taken; input ready drops only
// while a finished result waits. Configuration resets to period 1000000 ns,
// interval 10 ticks, base 30 and step 17; write it only while the block is idle.
module auto_brightness_ramp_top #(
    parameter int NUM_LEVELS = abr_pkg::NUM_LEVELS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [abr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [abr_pkg::PERIOD_W-1:0]   i_cfg_data,
    abr_in_if.sink                         i_in,
    abr_out_if.source                      o_out
);

    localparam abr_pkg::t_lvl TOP_LVL = abr_pkg::t_lvl'(NUM_LEVELS - 1);

    // configuration registers
    abr_pkg::t_period   r_period;
    abr_pkg::t_interval r_interval;
    abr_pkg::t_base     r_base;
    abr_pkg::t_step     r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= abr_pkg::PERIOD_RST;
            r_interval <= abr_pkg::INTERVAL_RST;
            r_base     <= abr_pkg::BASE_RST;
            r_step     <= abr_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            unique case (abr_pkg::t_cfg_idx'(i_cfg_idx))
                abr_pkg::CFG_PERIOD:   r_period   <= i_cfg_data;
                abr_pkg::CFG_INTERVAL: r_interval <= i_cfg_data[abr_pkg::INTERVAL_W-1:0];
                abr_pkg::CFG_BASE:     r_base     <= i_cfg_data[abr_pkg::BASE_W-1:0];
                abr_pkg::CFG_STEP:     r_step     <= i_cfg_data[abr_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic                     r_s1_valid;
    logic [abr_pkg::RAW_W-1:0] r_s1_raw;
    logic                     r_s1_ok;
    logic                     r_s2_valid;
    abr_pkg::t_lvl_info       r_s2_info;
    logic                     r_s3_valid;
    abr_pkg::t_lvl_info       r_s3_info;
    abr_pkg::t_prod           r_s3_prod;
    logic                     r_s4_valid;
    abr_pkg::t_lvl_info       r_s4_info;
    abr_pkg::t_quo            r_s4_y;
    abr_pkg::t_quo            r_s4_qest;
    logic                     r_out_valid;
    abr_pkg::t_lvl_info       r_out_info;
    abr_pkg::t_period         r_out_duty;

    // level state
    abr_pkg::t_lvl            r_cur;
    abr_pkg::t_lvl            r_goal;
    abr_pkg::t_interval       r_tick;

    logic adv;
    assign adv = !r_out_valid || o_out.ready;
    assign i_in.ready = adv;

    // goal pick from the halved reading
    abr_pkg::t_thr      reading;
    abr_pkg::t_lvl      goal_pick;
    abr_pkg::t_thr      thr;
    logic               sample;
    abr_pkg::t_lvl      n_goal;
    abr_pkg::t_lvl      n_cur;
    logic               n_upd;
    abr_pkg::t_interval n_tick;

    always_comb begin
        reading   = abr_pkg::t_thr'(r_s1_raw[abr_pkg::RAW_W-1:1]);
        goal_pick = TOP_LVL;
        thr       = '0;
        for (int lv = NUM_LEVELS - 2; lv >= 0; lv--) begin
            thr = abr_pkg::t_thr'(r_base)
                + abr_pkg::t_thr'(r_step) * abr_pkg::t_thr'(lv);
            if (reading <= thr) begin
                goal_pick = abr_pkg::t_lvl'(lv);
            end
        end
    end

    always_comb begin
        sample = r_tick >= r_interval;
        n_goal = (sample && r_s1_ok) ? goal_pick : r_goal;
        n_upd  = r_cur != n_goal;
        if (r_cur > n_goal) begin
            n_cur = r_cur - abr_pkg::t_lvl'(1);
        end else if (r_cur < n_goal) begin
            n_cur = r_cur + abr_pkg::t_lvl'(1);
        end else begin
            n_cur = r_cur;
        end
        n_tick = sample ? abr_pkg::t_interval'(1) : r_tick + abr_pkg::t_interval'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= TOP_LVL;
            r_goal <= TOP_LVL;
            r_tick <= '0;
        end else if (adv && r_s1_valid) begin
            r_cur  <= n_cur;
            r_goal <= n_goal;
            r_tick <= n_tick;
        end
    end

    // divide by 100: drop two bits, then divide by 25
    abr_pkg::t_quo  y;
    abr_pkg::t_wide recip_prod;
    abr_pkg::t_quo  rem;
    abr_pkg::t_quo  quo;

    always_comb begin
        y          = r_s3_prod[abr_pkg::PROD_W-1:2];
        recip_prod = abr_pkg::t_wide'(y) * abr_pkg::t_wide'(abr_pkg::RECIP_25);
        rem        = r_s4_y - r_s4_qest * abr_pkg::DIV_25;
        quo        = (rem >= abr_pkg::DIV_25) ? r_s4_qest + abr_pkg::t_quo'(1) : r_s4_qest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_in.valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_raw       <= i_in.raw_light;
            r_s1_ok        <= i_in.sample_ok;
            r_s2_info.cur  <= n_cur;
            r_s2_info.goal <= n_goal;
            r_s2_info.upd  <= n_upd;
            r_s3_info      <= r_s2_info;
            r_s3_prod      <= abr_pkg::t_prod'(abr_pkg::pct_of(r_s2_info.cur))
                            * abr_pkg::t_prod'(r_period);
            r_s4_info      <= r_s3_info;
            r_s4_y         <= y;
            r_s4_qest      <= abr_pkg::t_quo'(recip_prod[2*abr_pkg::QUO_W-1:abr_pkg::RECIP_SHIFT]);
            r_out_info     <= r_s4_info;
            r_out_duty     <= r_s4_info.upd ? quo[abr_pkg::PERIOD_W-1:0] : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.current_level = r_out_info.cur;
    assign o_out.goal_level    = r_out_info.goal;
    assign o_out.duty_ns       = r_out_duty;
    assign o_out.duty_update   = r_out_info.upd;

endmodule

/* rtl/abr_checker.sv */
// port level checks of the brightness ramp and their binding
`include "auto_brightness_ramp_top_defines.svh"

module abr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_current_level,
    input logic [26:0] i_duty_ns,
    input logic        i_duty_update
);

    logic       r_seen;
    logic [3:0] r_last;
    logic       xfer;

    assign xfer = i_out_valid && i_out_ready;

    // level of the previous result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (xfer) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_last <= i_current_level;
        end
    end

    `ABR_ASSERT(a_duty_zero_no_update, !i_out_valid || i_duty_update || i_duty_ns == 27'd0, "duty without update")
    `ABR_ASSERT(a_ready_when_empty, i_out_valid || i_in_ready, "input stalled with empty output")
    `ABR_ASSERT(a_update_matches_move, !(xfer && r_seen) || (i_duty_update == (i_current_level != r_last)), "update flag disagrees with level change")
    `ABR_ASSERT(a_single_step, !(xfer && r_seen) || i_current_level == r_last || i_current_level == r_last + 4'd1 || i_current_level + 4'd1 == r_last, "level jumped")
    `ABR_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_current_level) && $stable(i_duty_ns), "stalled result changed")

endmodule

bind auto_brightness_ramp_top abr_checker u_abr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_current_level (o_out.current_level),
    .i_duty_ns       (o_out.duty_ns),
    .i_duty_update   (o_out.duty_update)
);
